// ===== hdl/atp_pkg.sv =====
package atp_pkg;

   // Sizing of the parser.
   localparam int HASH_SPAN   = 5;
   localparam int NAME_MAX    = 10;
   localparam int LINE_MAX    = 255;
   localparam int LEN_W       = $clog2(LINE_MAX + 1);
   localparam int SUM_W       = ((LEN_W > 8) ? LEN_W : 8) + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [6:0] RADIX_RESET = 7'd38;

   // Character codes.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_T  = 8'h54;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_T  = 8'h74;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

   // Command mode codes.
   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_ACTIVE = 3'd1;
   localparam logic [2:0] MODE_READ   = 3'd2;
   localparam logic [2:0] MODE_TEST   = 3'd3;
   localparam logic [2:0] MODE_EXEC   = 3'd4;

   // One classified byte as it travels from the front end to the parser.
   typedef struct packed {
      logic [7:0]       char_byte;
      logic             is_term;
      logic             is_a;
      logic             is_t;
      logic             is_ext_prefix;
      logic             is_err_prefix;
      logic             is_equal;
      logic             is_qmark;
      logic             is_alnum;
      logic [5:0]       code;
      logic [LEN_W-1:0] pos;
      logic             ovf;
   } atp_entry_type;

endpackage

// ===== hdl/atp_ifs.sv =====
// Command byte channel.
interface atp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

// Parse result channel.
interface atp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        cmd_kind;
   logic [2:0]  cmd_mode;
   logic [31:0] hash_first;
   logic [31:0] hash_second;
   logic [7:0]  name_length;
   logic [7:0]  prefix_byte;

   modport source (output valid, output status, output cmd_kind, output cmd_mode,
                   output hash_first, output hash_second, output name_length,
                   output prefix_byte, input ready);
   modport sink (input valid, input status, input cmd_kind, input cmd_mode,
                 input hash_first, input hash_second, input name_length,
                 input prefix_byte, output ready);
endinterface

// ===== hdl/atp_front.sv =====
module atp_front
   import atp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   atp_req_if.sink       req_if,
   output logic          push_valid,
   input  logic          push_ready,
   output atp_entry_type push_entry
);

   logic [LEN_W-1:0] line_len_ff, line_len_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       c;
   logic             is_term;
   logic             is_upper;
   logic             is_lower;
   logic             is_digit;
   logic             room;
   logic             keep;
   logic             accept;

   assign c = req_if.char_in;

   // Character classes.
   assign is_term  = (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_NUL);
   assign is_upper = (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
   assign is_lower = (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign room     = line_len_ff < LEN_W'(LINE_MAX);

   // Bytes past the line limit and terminators of empty lines are dropped here.
   assign keep       = is_term ? ((line_len_ff != '0) || ovf_ff) : room;
   assign accept     = req_if.valid && req_if.ready;
   assign req_if.ready = push_ready;
   assign push_valid = req_if.valid && keep;

   always_comb begin
      push_entry               = '0;
      push_entry.char_byte     = c;
      push_entry.is_term       = is_term;
      push_entry.is_a          = (c == CHAR_UP_A) || (c == CHAR_LO_A);
      push_entry.is_t          = (c == CHAR_UP_T) || (c == CHAR_LO_T);
      push_entry.is_ext_prefix = (c == CHAR_PLUS) || (c == CHAR_HASH);
      push_entry.is_err_prefix = (c == CHAR_PCT) || (c == CHAR_STAR) ||
                                 (c == CHAR_CARET) || (c == CHAR_DOLLAR);
      push_entry.is_equal      = c == CHAR_EQUAL;
      push_entry.is_qmark      = c == CHAR_QMARK;
      push_entry.is_alnum      = is_upper || is_lower || is_digit;
      if (is_upper) begin
         push_entry.code = 6'(c - CHAR_UP_A);
      end else if (is_lower) begin
         push_entry.code = 6'(c - CHAR_LO_A);
      end else if (is_digit) begin
         push_entry.code = 6'(c - CHAR_ZERO);
      end
      push_entry.pos = line_len_ff;
      push_entry.ovf = ovf_ff;
   end

   // Line length and overflow tracking.
   always_comb begin
      line_len_in = line_len_ff;
      ovf_in      = ovf_ff;
      if (accept) begin
         if (is_term) begin
            line_len_in = '0;
            ovf_in      = 1'b0;
         end else if (room) begin
            line_len_in = line_len_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         line_len_ff <= line_len_in;
         ovf_ff      <= ovf_in;
      end
   end

endmodule

// ===== hdl/atp_queue.sv =====
module atp_queue
   import atp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  atp_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output atp_entry_type pop_entry
);

   atp_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/atp_parser.sv =====
module atp_parser
   import atp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [6:0]    hash_radix,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  atp_entry_type pop_entry,
   atp_rsp_if.source     rsp_if
);

   typedef enum logic [2:0] {
      PH_SEEK_A,
      PH_SEEK_T,
      PH_PREFIX,
      PH_NAME,
      PH_QMARK,
      PH_EQUAL,
      PH_EQ_QMARK,
      PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [31:0]      hash_one_ff, hash_one_in;
   logic [31:0]      hash_two_ff, hash_two_in;
   logic [5:0]       last_code_ff, last_code_in;
   logic [7:0]       name_cnt_ff, name_cnt_in;
   logic [2:0]       mode_ff, mode_in;
   logic             kind_ff, kind_in;
   logic [7:0]       prefix_ff, prefix_in;
   logic             err_ff, err_in;
   logic [LEN_W-1:0] at_pos_ff, at_pos_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff, rsp_status_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [2:0]       rsp_mode_ff, rsp_mode_in;
   logic [31:0]      rsp_hash_one_ff, rsp_hash_one_in;
   logic [31:0]      rsp_hash_two_ff, rsp_hash_two_in;
   logic [7:0]       rsp_len_ff, rsp_len_in;
   logic [7:0]       rsp_prefix_ff, rsp_prefix_in;

   logic             out_busy;
   logic             take;
   logic             term_take;
   logic [5:0]       code_new;
   logic [31:0]      acc_sel;
   logic [31:0]      mac_sum;
   logic [SUM_W-1:0] ext_len;
   logic [SUM_W-1:0] line_len;

   // A terminator waits while the result register is still occupied.
   assign out_busy  = rsp_valid_ff && !rsp_if.ready;
   assign pop_ready = !(pop_entry.is_term && out_busy);
   assign take      = pop_valid && pop_ready;
   assign term_take = take && pop_entry.is_term;

   // Multiply-add for one name character.
   assign code_new = pop_entry.is_alnum ? pop_entry.code : last_code_ff;
   assign acc_sel  = (name_cnt_ff < 8'(HASH_SPAN)) ? hash_one_ff : hash_two_ff;
   assign mac_sum  = 32'(acc_sel * 32'(hash_radix)) + 32'(code_new) + 32'd1;

   // Reported lengths before saturation.
   assign ext_len  = SUM_W'(at_pos_ff) + SUM_W'(3) + SUM_W'(name_cnt_ff);
   assign line_len = SUM_W'(pop_entry.pos);

   always_comb begin
      phase_in     = phase_ff;
      hash_one_in  = hash_one_ff;
      hash_two_in  = hash_two_ff;
      last_code_in = last_code_ff;
      name_cnt_in  = name_cnt_ff;
      mode_in      = mode_ff;
      kind_in      = kind_ff;
      prefix_in    = prefix_ff;
      err_in       = err_ff;
      at_pos_in    = at_pos_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_mode_in     = rsp_mode_ff;
      rsp_hash_one_in = rsp_hash_one_ff;
      rsp_hash_two_in = rsp_hash_two_ff;
      rsp_len_in      = rsp_len_ff;
      rsp_prefix_in   = rsp_prefix_ff;

      if (term_take) begin
         // Build the result of the finished line.
         rsp_valid_in    = 1'b1;
         rsp_status_in   = 1'b0;
         rsp_kind_in     = 1'b0;
         rsp_mode_in     = MODE_NONE;
         rsp_hash_one_in = '0;
         rsp_hash_two_in = '0;
         rsp_len_in      = '0;
         rsp_prefix_in   = '0;
         if (pop_entry.ovf || (phase_ff == PH_SEEK_A) || (phase_ff == PH_SEEK_T)) begin
            rsp_status_in = 1'b1;
         end else if ((phase_ff == PH_PREFIX) || ((phase_ff == PH_DONE) && !kind_ff)) begin
            rsp_len_in    = (line_len > SUM_W'(255)) ? 8'hFF : line_len[7:0];
            rsp_prefix_in = (phase_ff == PH_PREFIX) ? pop_entry.char_byte : prefix_ff;
         end else if (err_ff) begin
            rsp_status_in = 1'b1;
            rsp_kind_in   = 1'b1;
            rsp_prefix_in = prefix_ff;
         end else begin
            rsp_kind_in     = 1'b1;
            rsp_hash_one_in = hash_one_ff;
            rsp_hash_two_in = hash_two_ff;
            rsp_len_in      = (ext_len > SUM_W'(255)) ? 8'hFF : ext_len[7:0];
            rsp_prefix_in   = prefix_ff;
            case (phase_ff)
               PH_NAME: begin
                  rsp_mode_in = MODE_ACTIVE;
               end
               PH_QMARK: begin
                  rsp_mode_in = MODE_READ;
               end
               PH_EQUAL: begin
                  rsp_mode_in = MODE_EXEC;
               end
               PH_EQ_QMARK: begin
                  rsp_mode_in = MODE_TEST;
               end
               default: begin
                  rsp_mode_in = mode_ff;
               end
            endcase
         end

         // Start the next line from a clean state.
         phase_in     = PH_SEEK_A;
         hash_one_in  = '0;
         hash_two_in  = '0;
         last_code_in = '0;
         name_cnt_in  = '0;
         mode_in      = MODE_NONE;
         kind_in      = 1'b0;
         prefix_in    = '0;
         err_in       = 1'b0;
         at_pos_in    = '0;
      end else if (take) begin
         // Advance the line parser by one byte.
         case (phase_ff)
            PH_SEEK_A: begin
               if (pop_entry.is_a) begin
                  phase_in  = PH_SEEK_T;
                  at_pos_in = pop_entry.pos;
               end
            end
            PH_SEEK_T: begin
               if (pop_entry.is_t) begin
                  phase_in = PH_PREFIX;
               end else if (pop_entry.is_a) begin
                  at_pos_in = pop_entry.pos;
               end else begin
                  phase_in = PH_SEEK_A;
               end
            end
            PH_PREFIX: begin
               prefix_in = pop_entry.char_byte;
               if (pop_entry.is_ext_prefix) begin
                  kind_in  = 1'b1;
                  phase_in = PH_NAME;
               end else if (pop_entry.is_err_prefix) begin
                  kind_in  = 1'b1;
                  err_in   = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  kind_in  = 1'b0;
                  phase_in = PH_DONE;
               end
            end
            PH_NAME: begin
               if (pop_entry.is_equal) begin
                  phase_in = PH_EQUAL;
               end else if (pop_entry.is_qmark) begin
                  phase_in = PH_QMARK;
               end else begin
                  last_code_in = code_new;
                  if (name_cnt_ff < 8'(HASH_SPAN)) begin
                     hash_one_in = mac_sum;
                  end else if (name_cnt_ff < 8'(NAME_MAX)) begin
                     hash_two_in = mac_sum;
                  end
                  if (name_cnt_ff != 8'hFF) begin
                     name_cnt_in = name_cnt_ff + 8'd1;
                  end
               end
            end
            PH_QMARK, PH_EQ_QMARK: begin
               mode_in  = MODE_NONE;
               phase_in = PH_DONE;
            end
            PH_EQUAL: begin
               if (pop_entry.is_qmark) begin
                  phase_in = PH_EQ_QMARK;
               end else begin
                  mode_in  = MODE_EXEC;
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Parser state and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEEK_A;
         hash_one_ff  <= '0;
         hash_two_ff  <= '0;
         last_code_ff <= '0;
         name_cnt_ff  <= '0;
         mode_ff      <= MODE_NONE;
         kind_ff      <= 1'b0;
         prefix_ff    <= '0;
         err_ff       <= 1'b0;
         at_pos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hash_one_ff  <= hash_one_in;
         hash_two_ff  <= hash_two_in;
         last_code_ff <= last_code_in;
         name_cnt_ff  <= name_cnt_in;
         mode_ff      <= mode_in;
         kind_ff      <= kind_in;
         prefix_ff    <= prefix_in;
         err_ff       <= err_in;
         at_pos_ff    <= at_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff   <= rsp_status_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_mode_ff     <= rsp_mode_in;
      rsp_hash_one_ff <= rsp_hash_one_in;
      rsp_hash_two_ff <= rsp_hash_two_in;
      rsp_len_ff      <= rsp_len_in;
      rsp_prefix_ff   <= rsp_prefix_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.cmd_kind    = rsp_kind_ff;
   assign rsp_if.cmd_mode    = rsp_mode_ff;
   assign rsp_if.hash_first  = rsp_hash_one_ff;
   assign rsp_if.hash_second = rsp_hash_two_ff;
   assign rsp_if.name_length = rsp_len_ff;
   assign rsp_if.prefix_byte = rsp_prefix_ff;

   // While searching for AT nothing has been hashed or counted.
   a_seek_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SEEK_A) |-> (hash_one_ff == '0) && (hash_two_ff == '0) &&
                                  (name_cnt_ff == '0))
      else $error("parser state not clean while searching for AT");

   // Name characters are only counted once an extended prefix was seen.
   a_count_phase: assert property (@(posedge clock) disable iff (reset)
      (name_cnt_ff != '0) |-> (phase_ff == PH_NAME) || (phase_ff == PH_QMARK) ||
                              (phase_ff == PH_EQUAL) || (phase_ff == PH_EQ_QMARK) ||
                              (phase_ff == PH_DONE))
      else $error("name count outside extended command");

   // Basic lines and lines that fail before the prefix carry no hash and no mode.
   a_basic_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_kind_ff) |-> (rsp_hash_one_ff == '0) &&
                                         (rsp_hash_two_ff == '0) &&
                                         (rsp_mode_ff == MODE_NONE))
      else $error("basic result with hash or mode");

   // A new result appears only after a terminator was taken.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(term_take))
      else $error("result without terminator");

endmodule

// ===== hdl/at_command_line_parser_top.sv =====
// AT command line parser.
//
// Command line bytes arrive on req_if, one per transfer. Leading bytes are
// skipped up to the first AT; a CR, LF or NUL ends the line and yields one
// transfer on rsp_if with status, kind, mode, two name hashes, the name
// length and the prefix byte. A terminator on an empty line yields nothing.
// The user writes the hash multiplier through csr_wr_en and csr_wr_data only
// while the block is idle, which the block does not enforce; it resets to 38.
//
// A front end classifies each byte and tracks the line length, a two entry
// queue decouples it from the parser, which runs the line state machine and
// one 32 by 7 multiply-add per name byte. One byte is taken every cycle while
// the queue has room and no terminator waits on the result register. A
// terminator passes through the queue and the result register before its
// result is valid on rsp_if. When the receiver stalls, the result is held;
// the parser keeps taking bytes of the next line and only stops at that
// line's terminator, after which the queue fills and req_if.ready falls.
// Reset clears the parser, the queue and the result valid flag, and sets the
// multiplier to its default value.
module at_command_line_parser_top
   import atp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   atp_req_if.sink    req_if,
   atp_rsp_if.source  rsp_if,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   logic [6:0]    radix_ff, radix_in;
   logic          push_valid;
   logic          push_ready;
   atp_entry_type push_entry;
   logic          pop_valid;
   logic          pop_ready;
   atp_entry_type pop_entry;

   // Hash multiplier register.
   assign radix_in = csr_wr_en ? csr_wr_data : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   atp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   atp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   atp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .hash_radix (radix_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_if     (rsp_if)
   );

endmodule
